// ----- src/rso_pkg.sv -----
// ============================================================================
// rso_pkg
// Shared types and constants of the quadrature recursive oscillator.
// ============================================================================
package rso_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 31;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEPS_PER_QUADRANT = 2'd0,
      CSR_STEP_SINE          = 2'd1,
      CSR_STEP_COSINE        = 2'd2
   } csr_index_type;

   // Field widths
   localparam int unsigned STEPS_W = 16;
   localparam int unsigned COEF_W  = 31;
   localparam int unsigned INDEX_W = 18;
   localparam int unsigned SAMPLE_W = 32;

   // Packed payload widths, rounded up to whole bytes
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_FIELDS_W = 2 * SAMPLE_W + INDEX_W + 1;
   localparam int unsigned RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Register reset values (step constants for a twentieth of a quarter turn)
   localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd20;
   localparam logic [COEF_W-1:0]  SINE_RESET  = 31'd84244841;
   localparam logic [COEF_W-1:0]  COSINE_RESET = 31'd1070431801;

   // What to do with the held pair at the current index
   typedef enum logic [2:0] {
      QUAD_LOAD_0 = 3'd0,   // (0, +1)
      QUAD_LOAD_1 = 3'd1,   // (+1, 0)
      QUAD_LOAD_2 = 3'd2,   // (0, -1)
      QUAD_LOAD_3 = 3'd3,   // (-1, 0)
      QUAD_ROTATE = 3'd4    // rotate by the step angle
   } quad_type;

   typedef struct packed {
      logic     exact;
      quad_type quad;
   } step_ctrl_type;

endpackage

// ----- src/recursive_sine_cosine_oscillator_top.sv -----
// ============================================================================
// recursive_sine_cosine_oscillator_top
// Quadrature recursive oscillator: one sine/cosine sample per request item.
// ============================================================================
//
//  channel | ports         | payload (lowest bit first)
//  --------+---------------+---------------------------------------------------
//  request | req_t*        | tdata: restart
//  result  | rsp_t*        | tdata: sine_out, cosine_out, angle_index,
//          |               |        exact_point, zero fill
//  config  | csr_*         | index 0 steps, 1 step sine, 2 step cosine
//
//  One item per clock while results are taken: a request is taken in the
//  cycle it arrives and its sample appears in the result register on the
//  next cycle. The four multiplies and the saturating sums sit between the
//  held pair and itself, combinationally. A stalled result holds the request
//  side only while the result register is full and not taken. Synchronous
//  reset returns to angle zero and restores the default step constants.
// ============================================================================
module recursive_sine_cosine_oscillator_top #(
   parameter int unsigned FRACTION_BITS = 30
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: [0] restart, zero fill above
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rso_pkg::REQ_DATA_W-1:0]     req_tdata,
   // result: [31:0] sine_out, [63:32] cosine_out, [81:64] angle_index,
   //         [82] exact_point, zero fill above
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rso_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // configuration writes
   input  logic                               csr_we,
   input  logic [rso_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [rso_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rso_pkg::*;

   logic [STEPS_W-1:0]  steps_ff;
   logic [COEF_W-1:0]   step_sine_ff;
   logic [COEF_W-1:0]   step_cosine_ff;
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  angle_ff;
   logic                exact_ff;
   logic                accept;
   step_ctrl_type       ctrl;
   logic [INDEX_W-1:0]  angle_index;
   logic [SAMPLE_W-1:0] sine_out;
   logic [SAMPLE_W-1:0] cosine_out;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff       <= STEPS_RESET;
         step_sine_ff   <= SINE_RESET;
         step_cosine_ff <= COSINE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEPS_PER_QUADRANT: steps_ff       <= csr_wdata[STEPS_W-1:0];
            CSR_STEP_SINE:          step_sine_ff   <= csr_wdata[COEF_W-1:0];
            CSR_STEP_COSINE:        step_cosine_ff <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // Take a new item whenever the result register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   rso_index u_index (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .restart     (req_tdata[0]),
      .steps       (steps_ff),
      .ctrl        (ctrl),
      .angle_index (angle_index)
   );

   rso_rotate #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_rotate (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .quad        (ctrl.quad),
      .step_sine   (step_sine_ff),
      .step_cosine (step_cosine_ff),
      .sine_out    (sine_out),
      .cosine_out  (cosine_out)
   );

   // Result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Index and exact flag alongside the held pair
   always_ff @(posedge clock) begin
      if (accept) begin
         angle_ff <= angle_index;
         exact_ff <= ctrl.exact;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({exact_ff, angle_ff, cosine_out, sine_out});

endmodule

// ----- src/rso_index.sv -----
// ============================================================================
// rso_index
// Step index sequencer: picks the current index and the quadrant action.
// ============================================================================
module rso_index (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          restart,
   input  logic [rso_pkg::STEPS_W-1:0]   steps,
   output rso_pkg::step_ctrl_type        ctrl,
   output logic [rso_pkg::INDEX_W-1:0]   angle_index
);
   import rso_pkg::*;

   logic [INDEX_W-1:0] step_index_ff;
   logic [INDEX_W-1:0] step_index_in;
   logic [INDEX_W-1:0] full_count;
   logic [INDEX_W-1:0] half_count;
   logic [INDEX_W-1:0] quarter_count;
   logic [INDEX_W-1:0] three_count;
   logic [INDEX_W-1:0] cur_index;
   logic [INDEX_W-1:0] inc_index;

   // Quadrant boundaries
   always_comb begin
      quarter_count = INDEX_W'(steps);
      half_count    = {1'b0, steps, 1'b0};
      full_count    = {steps, 2'b00};
      three_count   = half_count + quarter_count;
   end

   // Restart or an out-of-range index falls back to angle zero
   always_comb begin
      if (restart || (step_index_ff >= full_count)) begin
         cur_index = '0;
      end else begin
         cur_index = step_index_ff;
      end
      inc_index = cur_index + INDEX_W'(1);
      if (inc_index >= full_count) begin
         step_index_in = '0;
      end else begin
         step_index_in = inc_index;
      end
   end

   // Exact load at each quadrant start, rotation elsewhere
   always_comb begin
      ctrl.exact = 1'b1;
      if (cur_index == '0) begin
         ctrl.quad = QUAD_LOAD_0;
      end else if (cur_index == quarter_count) begin
         ctrl.quad = QUAD_LOAD_1;
      end else if (cur_index == half_count) begin
         ctrl.quad = QUAD_LOAD_2;
      end else if (cur_index == three_count) begin
         ctrl.quad = QUAD_LOAD_3;
      end else begin
         ctrl.quad  = QUAD_ROTATE;
         ctrl.exact = 1'b0;
      end
   end

   assign angle_index = cur_index;

   // Advance the index on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         step_index_ff <= '0;
      end else if (advance) begin
         step_index_ff <= step_index_in;
      end
   end

endmodule

// ----- src/rso_rotate.sv -----
// ============================================================================
// rso_rotate
// Sine/cosine pair: exact quadrant loads or one rotation by the step angle.
// ============================================================================
module rso_rotate #(
   parameter int unsigned FRACTION_BITS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  rso_pkg::quad_type             quad,
   input  logic [rso_pkg::COEF_W-1:0]    step_sine,
   input  logic [rso_pkg::COEF_W-1:0]    step_cosine,
   output logic [rso_pkg::SAMPLE_W-1:0]  sine_out,
   output logic [rso_pkg::SAMPLE_W-1:0]  cosine_out
);
   import rso_pkg::*;

   // Held value, product and sum widths
   localparam int unsigned VAL_W  = FRACTION_BITS + 2;
   localparam int unsigned PROD_W = VAL_W + COEF_W + 1;
   localparam int unsigned SUM_W  = PROD_W + 1;
   localparam int unsigned EXT_W  = 64;

   localparam logic signed [SUM_W-1:0] SUM_ONE =
      {{(SUM_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
   localparam logic signed [VAL_W-1:0] VAL_ONE =
      {{(VAL_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

   logic signed [VAL_W-1:0]  sine_ff;
   logic signed [VAL_W-1:0]  sine_in;
   logic signed [VAL_W-1:0]  cosine_ff;
   logic signed [VAL_W-1:0]  cosine_in;
   logic signed [COEF_W:0]   coef_sin;
   logic signed [COEF_W:0]   coef_cos;
   logic signed [PROD_W-1:0] prod_sc;
   logic signed [PROD_W-1:0] prod_cs;
   logic signed [PROD_W-1:0] prod_cc;
   logic signed [PROD_W-1:0] prod_ss;
   logic signed [SUM_W-1:0]  sum_sine;
   logic signed [SUM_W-1:0]  sum_cosine;
   logic signed [SUM_W-1:0]  sat_sine;
   logic signed [SUM_W-1:0]  sat_cosine;
   logic signed [EXT_W-1:0]  sine_ext;
   logic signed [EXT_W-1:0]  cosine_ext;

   // Four products, each floored by an arithmetic shift
   always_comb begin
      coef_sin = {1'b0, step_sine};
      coef_cos = {1'b0, step_cosine};
      prod_sc  = (PROD_W'(sine_ff) * PROD_W'(coef_cos)) >>> FRACTION_BITS;
      prod_cs  = (PROD_W'(cosine_ff) * PROD_W'(coef_sin)) >>> FRACTION_BITS;
      prod_cc  = (PROD_W'(cosine_ff) * PROD_W'(coef_cos)) >>> FRACTION_BITS;
      prod_ss  = (PROD_W'(sine_ff) * PROD_W'(coef_sin)) >>> FRACTION_BITS;
   end

   // Angle addition, then clamp to plus or minus one
   always_comb begin
      sum_sine   = SUM_W'(prod_sc) + SUM_W'(prod_cs);
      sum_cosine = SUM_W'(prod_cc) - SUM_W'(prod_ss);
      if (sum_sine > SUM_ONE) begin
         sat_sine = SUM_ONE;
      end else if (sum_sine < -SUM_ONE) begin
         sat_sine = -SUM_ONE;
      end else begin
         sat_sine = sum_sine;
      end
      if (sum_cosine > SUM_ONE) begin
         sat_cosine = SUM_ONE;
      end else if (sum_cosine < -SUM_ONE) begin
         sat_cosine = -SUM_ONE;
      end else begin
         sat_cosine = sum_cosine;
      end
   end

   // Exact loads at quadrant starts, the rotated pair elsewhere
   always_comb begin
      case (quad)
         QUAD_LOAD_0: begin
            sine_in   = '0;
            cosine_in = VAL_ONE;
         end
         QUAD_LOAD_1: begin
            sine_in   = VAL_ONE;
            cosine_in = '0;
         end
         QUAD_LOAD_2: begin
            sine_in   = '0;
            cosine_in = -VAL_ONE;
         end
         QUAD_LOAD_3: begin
            sine_in   = -VAL_ONE;
            cosine_in = '0;
         end
         default: begin
            sine_in   = VAL_W'(sat_sine);
            cosine_in = VAL_W'(sat_cosine);
         end
      endcase
   end

   // Hold the pair; it is also the sample on the result side
   always_ff @(posedge clock) begin
      if (reset) begin
         sine_ff   <= '0;
         cosine_ff <= VAL_ONE;
      end else if (advance) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   // Sign-extend, then keep the low sample bits
   always_comb begin
      sine_ext   = EXT_W'(sine_ff);
      cosine_ext = EXT_W'(cosine_ff);
   end

   assign sine_out   = sine_ext[SAMPLE_W-1:0];
   assign cosine_out = cosine_ext[SAMPLE_W-1:0];

endmodule

// ----- tb/tb_recursive_sine_cosine_oscillator_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_recursive_sine_cosine_oscillator_top
// Self-checking bench for the quadrature recursive oscillator.
//
// A queue of restart items feeds a clocked driver and a clocked monitor
// checks each sample. A local fixed-point model of the oscillator computes
// the expected sine, cosine, index and exact flag per accepted item. A short
// directed part covers the quadrant loads, saturation, an index beyond a
// lowered count and a zero count. Random phases then sweep the step
// settings, with random idling on both sides and long result stalls.
// ============================================================================
module tb_recursive_sine_cosine_oscillator_top;
   import rso_pkg::*;

   localparam int unsigned FRACTION_BITS = 30;
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRACTION_BITS;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sine;
      logic [SAMPLE_W-1:0] cosine;
      logic [INDEX_W-1:0]  index;
      logic                exact;
   } osc_sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [0] restart, zero fill above
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] sine_out, [63:32] cosine_out, [81:64] angle_index,
   // [82] exact_point, zero fill above
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Local copy of the oscillator state and its step settings
   logic [STEPS_W-1:0] cfg_steps = STEPS_RESET;
   logic [COEF_W-1:0]  cfg_step_sine = SINE_RESET;
   logic [COEF_W-1:0]  cfg_step_cosine = COSINE_RESET;
   longint             osc_sine = 0;
   longint             osc_cosine = longint'(1) <<< FRACTION_BITS;
   logic [INDEX_W-1:0] osc_index = '0;

   bit             pending_restarts[$];
   osc_sample_type expected_samples[$];
   bit             no_idle = 1'b0;
   int unsigned    error_count = 0;
   int unsigned    items_taken = 0;
   int unsigned    samples_checked = 0;
   int unsigned    exact_seen = 0;
   int unsigned    restarts_taken = 0;
   int unsigned    settings_used = 0;

   recursive_sine_cosine_oscillator_top #(
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // floor(value * coef / one): arithmetic shift rounds toward minus infinity
   function automatic longint scaled_product(input longint value,
                                             input logic [COEF_W-1:0] coef);
      longint prod;
      prod = value * longint'(coef);
      return prod >>> FRACTION_BITS;
   endfunction

   function automatic longint clamp_unit(input longint value);
      longint unit;
      unit = longint'(1) <<< FRACTION_BITS;
      if (value > unit) return unit;
      if (value < -unit) return -unit;
      return value;
   endfunction

   // Produce the sample at the current index, then advance the index
   function automatic osc_sample_type advance_oscillator(input bit restart);
      int unsigned    n;
      int unsigned    full;
      int unsigned    j;
      int unsigned    nxt;
      longint         unit;
      longint         s;
      longint         c;
      osc_sample_type smp;
      n = cfg_steps;
      full = 4 * n;
      j = osc_index;
      unit = longint'(1) <<< FRACTION_BITS;
      smp.exact = 1'b1;
      if (restart || j >= full) j = 0;
      if (j == 0) begin
         osc_sine = 0;
         osc_cosine = unit;
      end else if (j == n) begin
         osc_sine = unit;
         osc_cosine = 0;
      end else if (j == 2 * n) begin
         osc_sine = 0;
         osc_cosine = -unit;
      end else if (j == 3 * n) begin
         osc_sine = -unit;
         osc_cosine = 0;
      end else begin
         s = osc_sine;
         c = osc_cosine;
         osc_sine = clamp_unit(scaled_product(s, cfg_step_cosine)
                               + scaled_product(c, cfg_step_sine));
         osc_cosine = clamp_unit(scaled_product(c, cfg_step_cosine)
                                 - scaled_product(s, cfg_step_sine));
         smp.exact = 1'b0;
      end
      smp.sine = osc_sine[SAMPLE_W-1:0];
      smp.cosine = osc_cosine[SAMPLE_W-1:0];
      smp.index = j[INDEX_W-1:0];
      nxt = j + 1;
      if (nxt >= full) nxt = 0;
      osc_index = nxt[INDEX_W-1:0];
      return smp;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s got %h, want %h", $time, field, got, want);
      error_count++;
   endtask

   // Driver: offer the next pending item once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_restarts.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
            req_tvalid <= 1'b1;
            req_tdata <= REQ_DATA_W'(pending_restarts.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus two long hold-offs to back the block up
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;
   int unsigned offered_taken = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) offered_taken++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (holds_done < 2 && pending_restarts.size() > 8 &&
                      offered_taken >= (holds_done == 0 ? 100 : 430)) begin
            hold_left = 120;
            holds_done++;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || $urandom_range(99) >= 8;
         end
      end
   end

   // Monitor: predict each accepted item, check each accepted sample
   always @(posedge clock) begin : monitor
      osc_sample_type got;
      osc_sample_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(advance_oscillator(req_tdata[0]));
            items_taken++;
            if (req_tdata[0]) restarts_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.sine = rsp_tdata[SAMPLE_W-1:0];
            got.cosine = rsp_tdata[2*SAMPLE_W-1:SAMPLE_W];
            got.index = rsp_tdata[2*SAMPLE_W+INDEX_W-1:2*SAMPLE_W];
            got.exact = rsp_tdata[2*SAMPLE_W+INDEX_W];
            samples_checked++;
            if (got.exact) exact_seen++;
            if (expected_samples.size() == 0) begin
               report_mismatch("sample with nothing outstanding", got.sine, '0);
            end else begin
               want = expected_samples.pop_front();
               if (got.sine !== want.sine)
                  report_mismatch("sine_out", got.sine, want.sine);
               if (got.cosine !== want.cosine)
                  report_mismatch("cosine_out", got.cosine, want.cosine);
               if (got.index !== want.index)
                  report_mismatch("angle_index", 32'(got.index), 32'(want.index));
               if (got.exact !== want.exact)
                  report_mismatch("exact_point", 32'(got.exact), 32'(want.exact));
            end
         end
      end
   end

   // Hold until every item is taken and every sample is back
   task automatic wait_for_quiet();
      do @(negedge clock);
      while (pending_restarts.size() != 0 || req_tvalid || expected_samples.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write all three step registers on consecutive cycles
   task automatic write_settings(input logic [STEPS_W-1:0] steps,
                                 input logic [COEF_W-1:0] s_coef,
                                 input logic [COEF_W-1:0] c_coef);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_STEPS_PER_QUADRANT;
      csr_wdata <= CSR_DATA_W'(steps);
      @(posedge clock);
      csr_index <= CSR_STEP_SINE;
      csr_wdata <= CSR_DATA_W'(s_coef);
      @(posedge clock);
      csr_index <= CSR_STEP_COSINE;
      csr_wdata <= CSR_DATA_W'(c_coef);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_steps = steps;
      cfg_step_sine = s_coef;
      cfg_step_cosine = c_coef;
      settings_used++;
   endtask

   task automatic queue_items(input int unsigned count, input int unsigned restart_pct);
      @(negedge clock);
      repeat (count) pending_restarts.push_back($urandom_range(99) < restart_pct);
   endtask

   task automatic queue_pattern(input bit pattern[]);
      @(negedge clock);
      foreach (pattern[k]) pending_restarts.push_back(pattern[k]);
   endtask

   initial begin : stimulus
      logic [STEPS_W-1:0] steps;
      logic [COEF_W-1:0]  s_coef;
      logic [COEF_W-1:0]  c_coef;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Default steps from reset: angle zero, then a few rotations
      queue_pattern('{0, 0, 0, 0, 0, 0});
      wait_for_quiet();
      // Count lowered below the held index; every index is a quadrant start
      write_settings(16'd1, COEF_ONE, '0);
      queue_pattern('{0, 0, 0, 0, 0});
      wait_for_quiet();
      // Unit step constants saturate both ways; restart at either end
      write_settings(16'd3, COEF_ONE, COEF_ONE);
      queue_pattern('{1, 0, 0, 0, 0, 0, 0, 1});
      wait_for_quiet();
      // Zero count: every sample sits at angle zero
      write_settings(16'd0, '0, '0);
      queue_pattern('{0, 1, 0});
      wait_for_quiet();

      // Random phases: mostly short quadrants so the loads come round often
      for (int p = 0; p < 12; p++) begin
         case ($urandom_range(3))
            0: begin
               s_coef = SINE_RESET;
               c_coef = COSINE_RESET;
            end
            1: begin
               s_coef = COEF_W'($urandom_range(COEF_ONE));
               c_coef = COEF_W'($urandom_range(COEF_ONE));
            end
            2: begin
               s_coef = $urandom_range(1) ? COEF_ONE : '0;
               c_coef = $urandom_range(1) ? COEF_ONE : '0;
            end
            default: begin
               s_coef = COEF_W'($urandom_range(1 << 26));
               c_coef = COEF_ONE - COEF_W'($urandom_range(1 << 24));
            end
         endcase
         if (p == 4) steps = '1;
         else if (p == 9) steps = '0;
         else if ($urandom_range(5) == 0) steps = STEPS_W'($urandom_range(300, 13));
         else steps = STEPS_W'($urandom_range(12, 1));
         write_settings(steps, s_coef, c_coef);
         no_idle = (p == 2);
         queue_items($urandom_range(60, 40), 3);
         wait_for_quiet();
         no_idle = 1'b0;
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d items (%0d restarts) over %0d step settings.",
               items_taken, restarts_taken, settings_used);
      $display("Checked %0d samples, %0d of them exact quadrant loads.",
               samples_checked, exact_seen);
      if (error_count == 0) begin
         $display("recursive_sine_cosine_oscillator_top: match");
      end else begin
         $display("recursive_sine_cosine_oscillator_top: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("recursive_sine_cosine_oscillator_top: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
src/rso_pkg.sv
src/rso_index.sv
src/rso_rotate.sv
src/recursive_sine_cosine_oscillator_top.sv
tb/tb_recursive_sine_cosine_oscillator_top.sv
